// ===== rtl/fpsl_pkg.sv =====
// Shared types, codes and defaults of the Frenet path sample lookup.
`timescale 1ns / 1ps
package fpsl_pkg;

	localparam int MAX_POINTS_DEF = 256;

	localparam logic [1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [1:0] FUNC_APPEND  = 2'd1;
	localparam logic [1:0] FUNC_EVAL    = 2'd2;
	localparam logic [1:0] FUNC_NEAREST = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FEW   = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_ORDER = 2'd3;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] l;
		logic signed [31:0] dl;
		logic signed [31:0] ddl;
	} point_t;

	typedef struct packed {
		logic        start;
		logic [32:0] mag;
		logic [31:0] num;
		logic [31:0] den;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quo;
	} md_rsp_t;

endpackage

// ===== rtl/fpsl_if.sv =====
// Request and response channel interfaces of the Frenet path sample lookup.
`timescale 1ns / 1ps
interface fpsl_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] point_s;
	logic signed [31:0] point_l;
	logic signed [31:0] point_dl;
	logic signed [31:0] point_ddl;
	logic signed [31:0] query_s;
	logic signed [31:0] box_start_s;
	logic signed [31:0] box_end_s;
	logic signed [31:0] box_start_l;
	logic signed [31:0] box_end_l;

	modport source (output valid, func, point_s, point_l, point_dl, point_ddl, query_s,
		box_start_s, box_end_s, box_start_l, box_end_l, input ready);
	modport sink (input valid, func, point_s, point_l, point_dl, point_ddl, query_s,
		box_start_s, box_end_s, box_start_l, box_end_l, output ready);
endinterface

interface fpsl_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_s;
	logic signed [31:0] out_l;
	logic signed [31:0] out_dl;
	logic signed [31:0] out_ddl;
	logic [30:0]        path_length;
	logic [1:0]         status;

	modport source (output valid, out_s, out_l, out_dl, out_ddl, path_length, status,
		input ready);
	modport sink (input valid, out_s, out_l, out_dl, out_ddl, path_length, status,
		output ready);
endinterface

// ===== rtl/fpsl_mem.sv =====
// Point table: four synchronous memories sharing one write and one read address.
`timescale 1ns / 1ps
module fpsl_mem import fpsl_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  point_t        wdata,
	input  logic [AW-1:0] raddr,
	output point_t        rdata
);

	logic signed [31:0] s_mem   [MAX_POINTS];
	logic signed [31:0] l_mem   [MAX_POINTS];
	logic signed [31:0] dl_mem  [MAX_POINTS];
	logic signed [31:0] ddl_mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			s_mem[waddr]   <= wdata.s;
			l_mem[waddr]   <= wdata.l;
			dl_mem[waddr]  <= wdata.dl;
			ddl_mem[waddr] <= wdata.ddl;
		end
		rdata.s   <= s_mem[raddr];
		rdata.l   <= l_mem[raddr];
		rdata.dl  <= dl_mem[raddr];
		rdata.ddl <= ddl_mem[raddr];
	end

endmodule

// ===== rtl/fpsl_muldiv.sv =====
// Bit-serial unit computing floor(mag * num / den) by shift-add then restoring division.
`timescale 1ns / 1ps
module fpsl_muldiv import fpsl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t md_req,
	output md_rsp_t md_rsp
);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MUL  = 2'd1;
	localparam logic [1:0] P_DIV  = 2'd2;

	logic [1:0]  phase_q;
	logic [6:0]  cnt_q;
	logic [32:0] mag_q;
	logic [31:0] num_q;
	logic [31:0] den_q;
	logic [64:0] prod_q;
	logic [31:0] rem_q;
	logic [32:0] quo_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	assign trial = {rem_q, prod_q[64]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (md_req.start) begin
						phase_q <= P_MUL;
						cnt_q   <= 7'd31;
					end
				end
				P_MUL: begin
					if (cnt_q == '0) begin
						phase_q <= P_DIV;
						cnt_q   <= 7'd64;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				P_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= P_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				mag_q  <= md_req.mag;
				num_q  <= md_req.num;
				den_q  <= md_req.den;
				prod_q <= '0;
				rem_q  <= '0;
			end
			P_MUL: begin
				prod_q <= {prod_q[63:0], 1'b0} + (num_q[31] ? {32'd0, mag_q} : 65'd0);
				num_q  <= {num_q[30:0], 1'b0};
			end
			P_DIV: begin
				rem_q  <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
				prod_q <= {prod_q[63:0], 1'b0};
				quo_q  <= {quo_q[31:0], fits};
			end
			default: ;
		endcase
	end

	assign md_rsp.done = done_q;
	assign md_rsp.quo  = quo_q;

endmodule

// ===== rtl/frenet_path_sample_lookup.sv =====
// Top level of the Frenet path sample lookup: sequencer around the point table.
`timescale 1ns / 1ps
// The block keeps up to MAX_POINTS path points (s, l, dl, ddl, signed Q16.16) appended in
// non-decreasing s, and answers one beat per request beat. Clear and append go straight
// to the finish state. Evaluate runs a binary search over the station memory, a read and
// a compare state per step, reads the two neighbors through S_EV0 and S_EV1, and then
// interpolates l, dl and ddl one after another in a shared bit-serial multiply-divide unit;
// an evaluate clamped to an end skips the interpolation and returns that end point. Nearest
// runs the same search for the box start and then scans the window point by point until it
// finds a point inside the box, leaves the window or runs out of points. The point memories
// have one registered read port, which sets the read-then-compare step of both search and
// scan. A finished beat waits in the output register while the next request is
// already taken.
module frenet_path_sample_lookup import fpsl_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fpsl_req_if.sink    req,
	fpsl_rsp_if.source  rsp
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRCH = 4'd1;
	localparam logic [3:0] S_SCMP = 4'd2;
	localparam logic [3:0] S_EV0  = 4'd3;
	localparam logic [3:0] S_EV1  = 4'd4;
	localparam logic [3:0] S_MDGO = 4'd5;
	localparam logic [3:0] S_MDWT = 4'd6;
	localparam logic [3:0] S_SCAN = 4'd7;
	localparam logic [3:0] S_NCMP = 4'd8;
	localparam logic [3:0] S_PT   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]         state_q;
	logic [1:0]         op_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] first_s_q;
	logic signed [31:0] last_s_q;
	logic signed [31:0] key_q;
	logic signed [31:0] be_q;
	logic signed [31:0] ls_q;
	logic signed [31:0] le_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [CW-1:0]      best_q;
	logic signed [33:0] bestd_q;
	logic               have_q;
	point_t             p0_q;
	point_t             p1_q;
	logic [31:0]        num_q;
	logic [31:0]        den_q;
	logic [1:0]         ch_q;
	logic               neg_q;
	point_t             res_q;
	logic [1:0]         status_q;

	logic               ov_q;
	point_t             o_q;
	logic [30:0]        len_q;
	logic [1:0]         ostat_q;

	logic               acc;
	logic               app_ok;
	logic [CW-1:0]      mid;
	logic [AW-1:0]      cnt_m1;
	logic [AW-1:0]      raddr;
	point_t             rd;
	point_t             wdata;
	md_req_t            md_req;
	md_rsp_t            md_rsp;
	logic signed [31:0] x0;
	logic signed [31:0] x1;
	logic signed [32:0] dx;
	logic signed [34:0] sum;
	logic signed [31:0] sat;
	logic               in_box;
	logic signed [33:0] lat_dist;
	logic signed [32:0] len_diff;
	logic [30:0]        len_now;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign app_ok    = (count_q != CW'(MAX_POINTS))
		&& ((count_q == '0) || (req.point_s >= last_s_q));
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign cnt_m1    = AW'(count_q - 1'b1);

	assign wdata.s   = req.point_s;
	assign wdata.l   = req.point_l;
	assign wdata.dl  = req.point_dl;
	assign wdata.ddl = req.point_ddl;

	// Box test and lateral distance of the point being scanned.
	assign in_box   = (rd.l >= ls_q) && (rd.l <= le_q);
	assign lat_dist = (rd.l > le_q) ? (34'(rd.l) - 34'(le_q)) : (34'(ls_q) - 34'(rd.l));

	// Read address follows the decision each state makes about the next access.
	always_comb begin
		raddr = '0;
		case (state_q)
			S_SRCH: begin
				if (lo_q < hi_q) begin
					raddr = mid[AW-1:0];
				end else if (op_q == FUNC_EVAL) begin
					if (lo_q == '0)
						raddr = '0;
					else if (lo_q >= count_q)
						raddr = cnt_m1;
					else
						raddr = AW'(lo_q - 1'b1);
				end else begin
					raddr = cnt_m1;
				end
			end
			S_EV0:  raddr = lo_q[AW-1:0];
			S_SCAN: raddr = (lo_q < count_q) ? lo_q[AW-1:0] : best_q[AW-1:0];
			S_NCMP: raddr = (rd.s <= be_q && in_box) ? lo_q[AW-1:0] : best_q[AW-1:0];
			default: raddr = '0;
		endcase
	end

	fpsl_mem #(.MAX_POINTS(MAX_POINTS)) u_mem (
		.clk   (clk),
		.we    (acc && req.func == FUNC_APPEND && app_ok),
		.waddr (count_q[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	// Operands of the channel under interpolation: 0 is l, 1 is dl, 2 is ddl.
	always_comb begin
		case (ch_q)
			2'd0: begin
				x0 = p0_q.l;
				x1 = p1_q.l;
			end
			2'd1: begin
				x0 = p0_q.dl;
				x1 = p1_q.dl;
			end
			default: begin
				x0 = p0_q.ddl;
				x1 = p1_q.ddl;
			end
		endcase
	end

	assign dx           = 33'(x1) - 33'(x0);
	assign md_req.start = (state_q == S_MDGO);
	assign md_req.mag   = dx[32] ? 33'(-dx) : 33'(dx);
	assign md_req.num   = num_q;
	assign md_req.den   = den_q;

	fpsl_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.md_req (md_req),
		.md_rsp (md_rsp)
	);

	assign sum = neg_q ? (35'(x0) - $signed({2'b00, md_rsp.quo}))
		: (35'(x0) + $signed({2'b00, md_rsp.quo}));
	assign sat = (sum > 35'sd2147483647) ? 32'sh7FFFFFFF
		: (sum < -35'sd2147483648) ? 32'sh80000000 : sum[31:0];

	// Path length from the first and last stored stations, clamped to the field range.
	assign len_diff = 33'(last_s_q) - 33'(first_s_q);
	assign len_now  = (count_q == '0 || len_diff < 0) ? 31'd0
		: (len_diff > 33'sh07FFFFFFF) ? 31'h7FFFFFFF : len_diff[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			// The output register loads a new beat or empties once its beat is taken.
			if (state_q == S_FIN && (!ov_q || rsp.ready))
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.func)
							FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= S_FIN;
							end
							FUNC_APPEND: begin
								if (app_ok)
									count_q <= count_q + 1'b1;
								state_q <= S_FIN;
							end
							FUNC_EVAL:
								state_q <= (count_q < CW'(2)) ? S_FIN : S_SRCH;
							default:
								state_q <= (count_q == '0) ? S_FIN : S_SRCH;
						endcase
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q)
						state_q <= S_SCMP;
					else if (op_q == FUNC_EVAL)
						state_q <= (lo_q == '0 || lo_q >= count_q) ? S_PT : S_EV0;
					else
						state_q <= (lo_q >= count_q) ? S_PT : S_SCAN;
				end
				S_SCMP: state_q <= S_SRCH;
				S_EV0:  state_q <= S_EV1;
				S_EV1:  state_q <= S_MDGO;
				S_MDGO: state_q <= S_MDWT;
				S_MDWT: begin
					if (md_rsp.done)
						state_q <= (ch_q == 2'd2) ? S_FIN : S_MDGO;
				end
				S_SCAN: state_q <= (lo_q < count_q) ? S_NCMP : S_PT;
				S_NCMP: state_q <= (rd.s > be_q || in_box) ? S_PT : S_SCAN;
				S_PT:   state_q <= S_FIN;
				S_FIN: begin
					if (!ov_q || rsp.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= req.func;
				be_q     <= req.box_end_s;
				ls_q     <= req.box_start_l;
				le_q     <= req.box_end_l;
				key_q    <= (req.func == FUNC_EVAL) ? req.query_s : req.box_start_s;
				lo_q     <= '0;
				hi_q     <= count_q;
				res_q    <= '0;
				status_q <= STAT_OK;
				if (acc) begin
					case (req.func)
						FUNC_APPEND: begin
							if (count_q == CW'(MAX_POINTS)) begin
								status_q <= STAT_FULL;
							end else if (!app_ok) begin
								status_q <= STAT_ORDER;
							end else begin
								last_s_q <= req.point_s;
								if (count_q == '0)
									first_s_q <= req.point_s;
							end
						end
						FUNC_EVAL: begin
							if (count_q < CW'(2))
								status_q <= STAT_FEW;
						end
						FUNC_NEAREST: begin
							if (count_q == '0)
								status_q <= STAT_FEW;
						end
						default: ;
					endcase
				end
			end
			S_SRCH: begin
				best_q <= lo_q;
				have_q <= 1'b0;
			end
			S_SCMP: begin
				if (rd.s < key_q)
					lo_q <= mid + 1'b1;
				else
					hi_q <= mid;
			end
			S_EV0: p0_q <= rd;
			S_EV1: begin
				p1_q    <= rd;
				num_q   <= 32'(key_q - p0_q.s);
				den_q   <= 32'(rd.s - p0_q.s);
				res_q.s <= key_q;
				ch_q    <= 2'd0;
			end
			S_MDGO: neg_q <= dx[32];
			S_MDWT: begin
				if (md_rsp.done) begin
					case (ch_q)
						2'd0:    res_q.l   <= sat;
						2'd1:    res_q.dl  <= sat;
						default: res_q.ddl <= sat;
					endcase
					ch_q <= ch_q + 1'b1;
				end
			end
			S_NCMP: begin
				// The first point of least lateral distance wins a tie.
				if (!(rd.s > be_q || in_box)) begin
					if (!have_q || lat_dist < bestd_q) begin
						have_q  <= 1'b1;
						bestd_q <= lat_dist;
						best_q  <= lo_q;
					end
					lo_q <= lo_q + 1'b1;
				end
			end
			S_PT: res_q <= rd;
			S_FIN: begin
				if (!ov_q || rsp.ready) begin
					o_q     <= res_q;
					len_q   <= len_now;
					ostat_q <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid       = ov_q;
	assign rsp.out_s       = o_q.s;
	assign rsp.out_l       = o_q.l;
	assign rsp.out_dl      = o_q.dl;
	assign rsp.out_ddl     = o_q.ddl;
	assign rsp.path_length = len_q;
	assign rsp.status      = ostat_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count above table capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != S_IDLE))
		else $error("sequencer did not leave idle after an accepted beat");

	a_md_done: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == S_MDWT))
		else $error("divide finished while the sequencer was not waiting");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && ov_q && !rsp.ready) |=> (state_q == S_FIN))
		else $error("result overwrote an untaken output beat");

endmodule
